// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
// Each macro expects i_clk and i_rst_n to exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ljpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpf_pkg
// Types, widths, stage indexes and helpers of the Lennard-Jones pair force.
// ----------------------------------------------------------------------------
package ljpf_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;
    localparam int COORD_W    = 32;
    localparam int MAG_W      = COORD_W + 1;
    localparam int MUL_W      = 64;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DIV_NUM_W  = 111;
    localparam int DIV_DEN_W  = 66;
    localparam int QUO_W      = 32;
    localparam int CAP_W      = 62;
    localparam int TM_W       = CAP_W + 1;
    localparam int NQ_W       = 78;

    localparam int MUL_LAT = 2;
    localparam int DIV_LAT = QUO_W + 1;

    // Pipeline stage indexes; a value "at stage k" sits in r_side[k].
    localparam int S_IN   = 0;
    localparam int S_R2   = S_IN + MUL_LAT + 1;
    localparam int S_QDIV = S_R2 + DIV_LAT;
    localparam int S_QREG = S_QDIV + 1;
    localparam int S_P    = S_QDIV + MUL_LAT;
    localparam int S_P3   = S_P + MUL_LAT;
    localparam int S_Q3   = S_P3 + 1;
    localparam int S_TM   = S_Q3 + 1;
    localparam int S_G    = S_TM + MUL_LAT + 1;
    localparam int S_H    = S_G + MUL_LAT + 1;
    localparam int S_NUM  = S_H + MUL_LAT;
    localparam int S_F    = S_NUM + DIV_LAT;
    localparam int S_OUT  = S_F + 1;

    localparam logic [CAP_W-1:0]      CAP_MAG      = '1;
    localparam logic [TM_W-1:0]       ONE_Q        = TM_W'(65536);
    localparam logic [CFG_DATA_W-1:0] SIGMA_RST    = CFG_DATA_W'(65536);
    localparam logic [CFG_DATA_W-1:0] WELL_RST     = CFG_DATA_W'(327680);
    localparam logic [COORD_W-1:0]    POS_SAT      = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0]    NEG_SAT      = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIGMA      = 1'b0,
        CFG_WELL_DEPTH = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
    } t_pair;

    typedef struct packed {
        logic signed [COORD_W-1:0] force_x;
        logic signed [COORD_W-1:0] force_y;
        logic                      clipped;
        logic                      coincident;
    } t_force;

    typedef struct packed {
        logic [MAG_W-1:0]     ax;
        logic [MAG_W-1:0]     ay;
        logic                 sx;
        logic                 sy;
        logic                 coinc;
        logic [DIV_DEN_W-1:0] r2;
        logic [NQ_W-1:0]      nq;
        logic [QUO_W-1:0]     q;
        logic                 qbig;
        logic [CAP_W-1:0]     q3;
        logic [TM_W-1:0]      tm;
        logic                 neg;
        logic [CAP_W-1:0]     g;
        logic [CAP_W-1:0]     h;
    } t_side;

    // Drop 16 fraction bits and cap the magnitude at 2^62-1.
    function automatic logic [CAP_W-1:0] f_cap_shr16(input logic [PROD_W-1:0] p);
        logic [CAP_W-1:0] res;
        if (|p[PROD_W-1:CAP_W+16]) begin
            res = CAP_MAG;
        end else begin
            res = p[CAP_W+15:16];
        end
        return res;
    endfunction

endpackage

// ===== design/ljpf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpf_if
// Valid/ready channels for particle pairs in and forces out.
// ----------------------------------------------------------------------------
interface ljpf_pair_if import ljpf_pkg::*; ();
    logic  valid;
    logic  ready;
    t_pair data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ljpf_force_if import ljpf_pkg::*; ();
    logic   valid;
    logic   ready;
    t_force data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ljpf_mul64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpf_mul64
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
// ----------------------------------------------------------------------------
module ljpf_mul64 import ljpf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic [PROD_W-1:0] o_p
);
    localparam int HW = MUL_W / 2;

    logic [MUL_W-1:0]  r_ll, r_lh, r_hl, r_hh;
    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[HW-1:0]     * i_b[HW-1:0];
            r_lh <= i_a[HW-1:0]     * i_b[MUL_W-1:HW];
            r_hl <= i_a[MUL_W-1:HW] * i_b[HW-1:0];
            r_hh <= i_a[MUL_W-1:HW] * i_b[MUL_W-1:HW];
            r_p  <= {{MUL_W{1'b0}}, r_ll}
                  + {{HW{1'b0}}, r_lh, {HW{1'b0}}}
                  + {{HW{1'b0}}, r_hl, {HW{1'b0}}}
                  + {r_hh, {MUL_W{1'b0}}};
        end
    end

    assign o_p = r_p;
endmodule

// ===== design/ljpf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpf_div
// Pipelined restoring divider: one quotient bit per stage, 32 bits, with an
// overflow flag when the quotient does not fit.
// ----------------------------------------------------------------------------
module ljpf_div import ljpf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic [QUO_W-1:0]     o_quo,
    output logic                 o_big
);
    logic [DIV_DEN_W-1:0] r_rem [0:QUO_W];
    logic [QUO_W-1:0]     r_low [0:QUO_W];
    logic [QUO_W-1:0]     r_quo [0:QUO_W];
    logic [DIV_DEN_W-1:0] r_den [0:QUO_W];
    logic                 r_big [0:QUO_W];

    logic [DIV_DEN_W:0]   w_trial [1:QUO_W];
    logic                 w_take  [1:QUO_W];

    always_comb begin
        for (int i = 1; i <= QUO_W; i++) begin
            w_trial[i] = {r_rem[i-1], r_low[i-1][QUO_W-1]};
            w_take[i]  = w_trial[i] >= {1'b0, r_den[i-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // The quotient fits in 32 bits only when the upper numerator is below the divisor.
            r_big[0] <= i_num[DIV_NUM_W-1:QUO_W]
                        >= {{(DIV_NUM_W-QUO_W-DIV_DEN_W){1'b0}}, i_den};
            r_rem[0] <= i_num[DIV_DEN_W+QUO_W-1:QUO_W];
            r_low[0] <= i_num[QUO_W-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            for (int i = 1; i <= QUO_W; i++) begin
                if (w_take[i]) begin
                    r_rem[i] <= DIV_DEN_W'(w_trial[i] - {1'b0, r_den[i-1]});
                end else begin
                    r_rem[i] <= w_trial[i][DIV_DEN_W-1:0];
                end
                r_low[i] <= {r_low[i-1][QUO_W-2:0], 1'b0};
                r_quo[i] <= {r_quo[i-1][QUO_W-2:0], w_take[i]};
                r_den[i] <= r_den[i-1];
                r_big[i] <= r_big[i-1];
            end
        end
    end

    assign o_quo = r_quo[QUO_W];
    assign o_big = r_big[QUO_W];
endmodule

// ===== design/lennard_jones_pair_force.sv =====
`timescale 1ns / 1ps
// Throughput: one pair per cycle; the whole pipeline advances together and holds
// in place while the output word waits and the last stage is occupied.
// The divider stages (one quotient bit each) set most of the depth.
// Reset: synchronous, active low; clears all stage valid bits and loads the
// default sigma (1.0) and well depth (5.0).
// ----------------------------------------------------------------------------
// lennard_jones_pair_force
// Lennard-Jones 12-6 force on particle i from particle j in 2D, Q16.16.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lennard_jones_pair_force import ljpf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ljpf_pair_if.sink             i_pair,
    ljpf_force_if.source          o_force
);
    logic [CFG_DATA_W-1:0] r_sigma;
    logic [CFG_DATA_W-1:0] r_well;

    t_side  r_side [0:S_F];
    t_side  n_side [0:S_F];
    logic   r_vld  [0:S_OUT];
    t_force r_out;
    t_force n_out;
    logic   w_adv;

    logic [PROD_W-1:0] w_ax2, w_ay2, w_sig2, w_qq, w_q3p, w_gp, w_hp, w_fxp, w_fyp;
    logic [QUO_W-1:0]  w_q, w_mx, w_my;
    logic              w_qbig, w_bigx, w_bigy;
    logic [35:0]       w_well24;

    assign w_adv        = !r_vld[S_OUT] || o_force.ready;
    assign i_pair.ready = w_adv;
    assign w_well24     = {1'b0, r_well, 4'b0} + {2'b0, r_well, 3'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma <= SIGMA_RST;
            r_well  <= WELL_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SIGMA:      r_sigma <= i_cfg_data;
                CFG_WELL_DEPTH: r_well  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Arithmetic units; all hold with the shared advance enable.
    ljpf_mul64 u_mul_ax (.i_clk, .i_en(w_adv), .i_a({31'b0, r_side[S_IN].ax}),
                         .i_b({31'b0, r_side[S_IN].ax}), .o_p(w_ax2));
    ljpf_mul64 u_mul_ay (.i_clk, .i_en(w_adv), .i_a({31'b0, r_side[S_IN].ay}),
                         .i_b({31'b0, r_side[S_IN].ay}), .o_p(w_ay2));
    ljpf_mul64 u_mul_sg (.i_clk, .i_en(w_adv), .i_a({33'b0, r_sigma}),
                         .i_b({33'b0, r_sigma}), .o_p(w_sig2));

    ljpf_div u_div_q (.i_clk, .i_en(w_adv), .i_num({33'b0, r_side[S_R2].nq}),
                      .i_den(r_side[S_R2].r2), .o_quo(w_q), .o_big(w_qbig));

    ljpf_mul64 u_mul_qq (.i_clk, .i_en(w_adv), .i_a({32'b0, w_q}), .i_b({32'b0, w_q}),
                         .o_p(w_qq));
    ljpf_mul64 u_mul_q3 (.i_clk, .i_en(w_adv), .i_a({16'b0, w_qq[63:16]}),
                         .i_b({32'b0, r_side[S_P].q}), .o_p(w_q3p));
    ljpf_mul64 u_mul_g  (.i_clk, .i_en(w_adv), .i_a({2'b0, r_side[S_TM].q3}),
                         .i_b({1'b0, r_side[S_TM].tm}), .o_p(w_gp));
    ljpf_mul64 u_mul_h  (.i_clk, .i_en(w_adv), .i_a({28'b0, w_well24}),
                         .i_b({2'b0, r_side[S_G].g}), .o_p(w_hp));
    ljpf_mul64 u_mul_fx (.i_clk, .i_en(w_adv), .i_a({2'b0, r_side[S_H].h}),
                         .i_b({31'b0, r_side[S_H].ax}), .o_p(w_fxp));
    ljpf_mul64 u_mul_fy (.i_clk, .i_en(w_adv), .i_a({2'b0, r_side[S_H].h}),
                         .i_b({31'b0, r_side[S_H].ay}), .o_p(w_fyp));

    ljpf_div u_div_fx (.i_clk, .i_en(w_adv), .i_num({w_fxp[94:0], 16'b0}),
                       .i_den(r_side[S_NUM].r2), .o_quo(w_mx), .o_big(w_bigx));
    ljpf_div u_div_fy (.i_clk, .i_en(w_adv), .i_num({w_fyp[94:0], 16'b0}),
                       .i_den(r_side[S_NUM].r2), .o_quo(w_my), .o_big(w_bigy));

    always_comb begin
        logic [MAG_W-1:0] dx;
        logic [MAG_W-1:0] dy;
        logic [TM_W-1:0]  two_q3;
        dx = {i_pair.data.first_x[COORD_W-1], i_pair.data.first_x}
           - {i_pair.data.second_x[COORD_W-1], i_pair.data.second_x};
        dy = {i_pair.data.first_y[COORD_W-1], i_pair.data.first_y}
           - {i_pair.data.second_y[COORD_W-1], i_pair.data.second_y};

        n_side[S_IN]       = '0;
        n_side[S_IN].sx    = dx[MAG_W-1];
        n_side[S_IN].sy    = dy[MAG_W-1];
        n_side[S_IN].ax    = dx[MAG_W-1] ? (MAG_W'(0) - dx) : dx;
        n_side[S_IN].ay    = dy[MAG_W-1] ? (MAG_W'(0) - dy) : dy;
        n_side[S_IN].coinc = (dx == '0) && (dy == '0);

        for (int i = 1; i <= S_F; i++) begin
            n_side[i] = r_side[i-1];
        end

        n_side[S_R2].r2 = {1'b0, w_ax2[DIV_DEN_W-2:0]} + {1'b0, w_ay2[DIV_DEN_W-2:0]};
        n_side[S_R2].nq = {w_sig2[CAP_W-1:0], 16'b0};

        n_side[S_QREG].q    = w_q;
        n_side[S_QREG].qbig = w_qbig;

        // A quotient of 2^32 or more already drives q^3 past the cap.
        n_side[S_Q3].q3 = r_side[S_P3].qbig ? CAP_MAG : f_cap_shr16(w_q3p);

        two_q3 = {r_side[S_Q3].q3, 1'b0};
        if (two_q3 >= ONE_Q) begin
            n_side[S_TM].tm  = two_q3 - ONE_Q;
            n_side[S_TM].neg = 1'b0;
        end else begin
            n_side[S_TM].tm  = ONE_Q - two_q3;
            n_side[S_TM].neg = 1'b1;
        end

        n_side[S_G].g = f_cap_shr16(w_gp);
        n_side[S_H].h = f_cap_shr16(w_hp);
    end

    // Sign, saturation and the coincident override.
    always_comb begin
        logic neg_x;
        logic neg_y;
        logic clip_x;
        logic clip_y;
        neg_x = r_side[S_F].sx ^ r_side[S_F].neg;
        neg_y = r_side[S_F].sy ^ r_side[S_F].neg;
        n_out = '0;
        if (neg_x) begin
            clip_x = w_bigx || (w_mx[QUO_W-1] && (|w_mx[QUO_W-2:0]));
            n_out.force_x = clip_x ? NEG_SAT : (QUO_W'(0) - w_mx);
        end else begin
            clip_x = w_bigx || w_mx[QUO_W-1];
            n_out.force_x = clip_x ? POS_SAT : w_mx;
        end
        if (neg_y) begin
            clip_y = w_bigy || (w_my[QUO_W-1] && (|w_my[QUO_W-2:0]));
            n_out.force_y = clip_y ? NEG_SAT : (QUO_W'(0) - w_my);
        end else begin
            clip_y = w_bigy || w_my[QUO_W-1];
            n_out.force_y = clip_y ? POS_SAT : w_my;
        end
        n_out.clipped = clip_x || clip_y;
        if (r_side[S_F].coinc) begin
            n_out = '0;
            n_out.coincident = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i <= S_F; i++) begin
                r_side[i] <= n_side[i];
            end
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= S_OUT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_pair.valid;
            for (int i = 1; i <= S_OUT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    assign o_force.valid = r_vld[S_OUT];
    assign o_force.data  = r_out;

    `ASSERT_IMPLIES(a_coinc_zero, o_force.valid && o_force.data.coincident, o_force.data.force_x == '0 && o_force.data.force_y == '0 && !o_force.data.clipped, "coincident word carries a force")
    `ASSERT_IMPLIES(a_flags_excl, o_force.valid, !(o_force.data.clipped && o_force.data.coincident), "clipped and coincident both set")
    `ASSERT_NEXT(a_accept_enters, i_pair.valid && i_pair.ready, r_vld[S_IN], "accepted pair did not enter the pipeline")
    `ASSERT_NEXT(a_stall_holds, i_rst_n && !w_adv, $stable(r_vld[S_Q3]) && $stable(r_vld[S_F]), "pipeline moved during a stall")
endmodule
